@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SSA step unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BDM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BDM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bdm_ssa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSA step package
// Widths, codes and types shared by the SSA step unit and its multiplier.
// ----------------------------------------------------------------------------
package bdm_ssa_pkg;

   localparam int COUNT_BITS  = 40;
   localparam int RANDOM_BITS = 32;
   localparam int RATE_BITS   = 48;
   localparam int TARGET_BITS = 40;
   localparam int FRAC_BITS   = 40;
   localparam int LIMB_BITS   = 32;

   localparam int PROD_W = COUNT_BITS + RATE_BITS;
   localparam int PMD_W  = PROD_W + RATE_BITS - FRAC_BITS;
   localparam int SUM_W  = PMD_W + 2;
   localparam int LHS_W  = SUM_W + RANDOM_BITS;

   localparam int A_LIMBS = (SUM_W + LIMB_BITS - 1) / LIMB_BITS;
   localparam int B_LIMBS = (RATE_BITS + LIMB_BITS - 1) / LIMB_BITS;
   localparam int A_W     = A_LIMBS * LIMB_BITS;
   localparam int B_W     = B_LIMBS * LIMB_BITS;
   localparam int ACC_W   = (A_LIMBS + B_LIMBS) * LIMB_BITS;

   localparam int TERM_COUNT  = 5;
   localparam int K_W         = 3;
   localparam int CSR_INDEX_W = 2;

   localparam logic [RATE_BITS-1:0]  FITNESS_ONE = RATE_BITS'(1) << FRAC_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEATH_RATE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MUTATION_RATE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MUTANT_FITNESS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_SIZE    = 2'd3;

   typedef enum logic [K_W-1:0] {
      RX_WILD_BIRTH = 3'd0,
      RX_WILD_DEATH = 3'd1,
      RX_MUT_BIRTH  = 3'd2,
      RX_MUT_DEATH  = 3'd3,
      RX_MUTATION   = 3'd4,
      RX_NONE       = 3'd5
   } reaction_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_WD,
      ST_MUL_MB,
      ST_MUL_MD,
      ST_MUL_MU,
      ST_TOTAL,
      ST_CHECK,
      ST_MUL_LHS,
      ST_SCAN,
      ST_APPLY,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] wild_count;
      logic [COUNT_BITS-1:0] mutant_count;
      logic [COUNT_BITS-1:0] event_count;
      reaction_type          reaction;
      logic                  target_reached;
      logic                  extinct;
      logic                  saturated;
   } rsp_data_type;

endpackage

@@ design/bdm_ssa_csr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSA step register write channel
// Valid/ready write transaction carrying a register index and data.
// ----------------------------------------------------------------------------
interface bdm_ssa_csr_if import bdm_ssa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [RATE_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/bdm_ssa_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSA step request channel
// Valid/ready channel carrying one load or step transaction.
// ----------------------------------------------------------------------------
interface bdm_ssa_req_if import bdm_ssa_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [COUNT_BITS-1:0]  initial_wild;
   logic [RANDOM_BITS-1:0] random_fraction;

   modport source (output valid, action, initial_wild, random_fraction, input ready);
   modport sink   (input valid, action, initial_wild, random_fraction, output ready);
endinterface

@@ design/bdm_ssa_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSA step response channel
// Valid/ready channel carrying the counts and flags after one transaction.
// ----------------------------------------------------------------------------
interface bdm_ssa_rsp_if import bdm_ssa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] wild_count;
   logic [COUNT_BITS-1:0] mutant_count;
   logic [COUNT_BITS-1:0] event_count;
   logic [K_W-1:0]        reaction;
   logic                  target_reached;
   logic                  extinct;
   logic                  saturated;

   modport source (output valid, wild_count, mutant_count, event_count, reaction,
                   target_reached, extinct, saturated, input ready);
   modport sink   (input valid, wild_count, mutant_count, event_count, reaction,
                   target_reached, extinct, saturated, output ready);
endinterface

@@ design/bdm_ssa_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSA step limb multiplier
// Iterative wide multiplier: one 32x32 partial product per cycle, registered,
// then shifted and added into the accumulator. Pulses done with the product.
// ----------------------------------------------------------------------------
module bdm_ssa_mul import bdm_ssa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   a,
   input  logic [B_W-1:0]   b,
   output logic             done,
   output logic [ACC_W-1:0] product
);

   localparam int AI_W = $clog2(A_LIMBS);
   localparam int BJ_W = $clog2(B_LIMBS);
   localparam int PS_W = $clog2(A_LIMBS + B_LIMBS - 1);
   localparam logic [AI_W-1:0] AI_LAST = AI_W'(A_LIMBS - 1);
   localparam logic [BJ_W-1:0] BJ_LAST = BJ_W'(B_LIMBS - 1);

   logic [A_W-1:0]         a_ff, a_in;
   logic [B_W-1:0]         b_ff, b_in;
   logic                   run_ff, run_in;
   logic [AI_W-1:0]        ai_ff, ai_in;
   logic [BJ_W-1:0]        bj_ff, bj_in;
   logic [2*LIMB_BITS-1:0] p_ff, p_in;
   logic [PS_W-1:0]        ps_ff, ps_in;
   logic                   pv_ff, pv_in;
   logic                   plast_ff, plast_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   done_ff, done_in;

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      run_in   = run_ff;
      ai_in    = ai_ff;
      bj_in    = bj_ff;
      p_in     = p_ff;
      ps_in    = ps_ff;
      pv_in    = 1'b0;
      plast_in = 1'b0;
      acc_in   = acc_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in   = a;
         b_in   = b;
         run_in = 1'b1;
         ai_in  = '0;
         bj_in  = '0;
         acc_in = '0;
      end else begin
         if (run_ff) begin
            p_in  = a_ff[ai_ff*LIMB_BITS +: LIMB_BITS] * b_ff[bj_ff*LIMB_BITS +: LIMB_BITS];
            ps_in = PS_W'(ai_ff) + PS_W'(bj_ff);
            pv_in = 1'b1;
            if (bj_ff == BJ_LAST) begin
               bj_in = '0;
               if (ai_ff == AI_LAST) begin
                  run_in   = 1'b0;
                  plast_in = 1'b1;
               end else begin
                  ai_in = ai_ff + AI_W'(1);
               end
            end else begin
               bj_in = bj_ff + BJ_W'(1);
            end
         end
         if (pv_ff) begin
            acc_in  = acc_ff + (ACC_W'(p_ff) << (ps_ff * LIMB_BITS));
            done_in = plast_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         ai_ff    <= '0;
         bj_ff    <= '0;
         pv_ff    <= 1'b0;
         plast_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         ai_ff    <= ai_in;
         bj_ff    <= bj_in;
         pv_ff    <= pv_in;
         plast_ff <= plast_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
      ps_ff  <= ps_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ design/birth_death_mutation_ssa_step_unit.sv @@
`timescale 1ns / 1ps
// A load or an extinct step goes from idle straight to finish. A reaction step forms the
// propensity products in the shared 32x32 limb multiplier, sums the five terms, scales the
// total by the random fraction in a fifth multiplier pass, then runs the cumulative-sum scan,
// apply and finish. A step with zero total propensity finishes after the total. One
// transaction at a time; the next is accepted in idle after finish registers the response,
// which waits while an earlier response is not yet taken. Synchronous reset clears counts and rates (fitness to 1.0).
// ----------------------------------------------------------------------------
// SSA step unit
// Loads the counts, or runs one Gillespie direct-method reaction step over wild-type and mutant counts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module birth_death_mutation_ssa_step_unit import bdm_ssa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   bdm_ssa_csr_if.sink   csr_if,
   bdm_ssa_req_if.sink   req_if,
   bdm_ssa_rsp_if.source rsp_if
);

   localparam logic [K_W-1:0] K_LAST    = K_W'(TERM_COUNT - 1);
   localparam logic [K_W-1:0] SCAN_LAST = K_W'(TERM_COUNT - 2);

   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  wild_ff, wild_in;
   logic [COUNT_BITS-1:0]  mutant_ff, mutant_in;
   logic [COUNT_BITS-1:0]  events_ff, events_in;
   logic [RATE_BITS-1:0]   death_ff, death_in;
   logic [RATE_BITS-1:0]   mutation_ff, mutation_in;
   logic [RATE_BITS-1:0]   fitness_ff, fitness_in;
   logic [TARGET_BITS-1:0] target_ff, target_in;
   logic [RANDOM_BITS-1:0] frac_ff, frac_in;
   logic [PROD_W-1:0]      pwd_ff, pwd_in;
   logic [PROD_W-1:0]      pmb_ff, pmb_in;
   logic [PMD_W-1:0]       pmd_ff, pmd_in;
   logic [PROD_W-1:0]      pmu_ff, pmu_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [LHS_W-1:0]       lhs_ff, lhs_in;
   logic [K_W-1:0]         k_ff, k_in;
   reaction_type           reaction_ff, reaction_in;
   logic                   ext_ff, ext_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_data_type           rsp_ff, rsp_in;

   logic                   req_ready;
   logic [K_W-1:0]         tsel;
   logic [SUM_W-1:0]       term;
   logic [SUM_W-1:0]       sum_add;
   logic                   mul_start;
   logic [A_W-1:0]         mul_a;
   logic [B_W-1:0]         mul_b;
   logic                   mul_done;
   logic [ACC_W-1:0]       mul_product;

   bdm_ssa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      case (reaction_type'(tsel))
         RX_WILD_BIRTH: term = SUM_W'({wild_ff, {FRAC_BITS{1'b0}}});
         RX_WILD_DEATH: term = SUM_W'(pwd_ff);
         RX_MUT_BIRTH:  term = SUM_W'(pmb_ff);
         RX_MUT_DEATH:  term = SUM_W'(pmd_ff);
         RX_MUTATION:   term = SUM_W'(pmu_ff);
         default:       term = '0;
      endcase
   end

   assign sum_add = sum_ff + term;

   always_comb begin
      death_in    = death_ff;
      mutation_in = mutation_ff;
      fitness_in  = fitness_ff;
      target_in   = target_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_DEATH_RATE:     death_in    = csr_if.data;
            CSR_MUTATION_RATE:  mutation_in = csr_if.data;
            CSR_MUTANT_FITNESS: fitness_in  = csr_if.data;
            CSR_TARGET_SIZE:    target_in   = csr_if.data[TARGET_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      wild_in      = wild_ff;
      mutant_in    = mutant_ff;
      events_in    = events_ff;
      frac_in      = frac_ff;
      pwd_in       = pwd_ff;
      pmb_in       = pmb_ff;
      pmd_in       = pmd_ff;
      pmu_in       = pmu_ff;
      sum_in       = sum_ff;
      lhs_in       = lhs_ff;
      k_in         = k_ff;
      reaction_in  = reaction_ff;
      ext_in       = ext_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      tsel         = k_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               frac_in     = req_if.random_fraction;
               reaction_in = RX_NONE;
               ext_in      = 1'b0;
               sat_in      = 1'b0;
               if (req_if.action == ACT_LOAD) begin
                  wild_in   = req_if.initial_wild;
                  mutant_in = '0;
                  events_in = '0;
                  ext_in    = (req_if.initial_wild == '0);
                  state_in  = ST_FINISH;
               end else if (wild_ff == '0 && mutant_ff == '0) begin
                  ext_in   = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = A_W'(wild_ff);
                  mul_b     = B_W'(death_ff);
                  state_in  = ST_MUL_WD;
               end
            end
         end
         ST_MUL_WD: begin
            if (mul_done) begin
               pwd_in    = mul_product[PROD_W-1:0];
               mul_start = 1'b1;
               mul_a     = A_W'(mutant_ff);
               mul_b     = B_W'(fitness_ff);
               state_in  = ST_MUL_MB;
            end
         end
         ST_MUL_MB: begin
            if (mul_done) begin
               pmb_in    = mul_product[PROD_W-1:0];
               mul_start = 1'b1;
               mul_a     = A_W'(mul_product[PROD_W-1:0]);
               mul_b     = B_W'(death_ff);
               state_in  = ST_MUL_MD;
            end
         end
         ST_MUL_MD: begin
            if (mul_done) begin
               pmd_in    = mul_product[FRAC_BITS +: PMD_W];
               mul_start = 1'b1;
               mul_a     = A_W'(wild_ff);
               mul_b     = B_W'(mutation_ff);
               state_in  = ST_MUL_MU;
            end
         end
         ST_MUL_MU: begin
            if (mul_done) begin
               pmu_in   = mul_product[PROD_W-1:0];
               sum_in   = '0;
               k_in     = '0;
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            sum_in = sum_add;
            if (k_ff == K_LAST) begin
               state_in = ST_CHECK;
            end else begin
               k_in = k_ff + K_W'(1);
            end
         end
         ST_CHECK: begin
            if (sum_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               mul_start = 1'b1;
               mul_a     = A_W'(sum_ff);
               mul_b     = B_W'(frac_ff);
               state_in  = ST_MUL_LHS;
            end
         end
         ST_MUL_LHS: begin
            tsel = '0;
            if (mul_done) begin
               lhs_in   = mul_product[LHS_W-1:0];
               sum_in   = term;
               k_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            tsel = k_ff + K_W'(1);
            if (lhs_ff < {sum_ff, {RANDOM_BITS{1'b0}}}) begin
               reaction_in = reaction_type'(k_ff);
               state_in    = ST_APPLY;
            end else if (k_ff == SCAN_LAST) begin
               reaction_in = RX_MUTATION;
               state_in    = ST_APPLY;
            end else begin
               sum_in = sum_add;
               k_in   = k_ff + K_W'(1);
            end
         end
         ST_APPLY: begin
            case (reaction_ff)
               RX_WILD_BIRTH: begin
                  if (wild_ff == COUNT_MAX) sat_in = 1'b1;
                  else wild_in = wild_ff + COUNT_BITS'(1);
               end
               RX_WILD_DEATH: begin
                  if (wild_ff != '0) wild_in = wild_ff - COUNT_BITS'(1);
               end
               RX_MUT_BIRTH: begin
                  if (mutant_ff == COUNT_MAX) sat_in = 1'b1;
                  else mutant_in = mutant_ff + COUNT_BITS'(1);
               end
               RX_MUT_DEATH: begin
                  if (mutant_ff != '0) mutant_in = mutant_ff - COUNT_BITS'(1);
               end
               RX_MUTATION: begin
                  if (mutant_ff == COUNT_MAX) sat_in = 1'b1;
                  else mutant_in = mutant_ff + COUNT_BITS'(1);
                  if (events_ff == COUNT_MAX) sat_in = 1'b1;
                  else events_in = events_ff + COUNT_BITS'(1);
               end
               default: ;
            endcase
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.wild_count     = wild_ff;
               rsp_in.mutant_count   = mutant_ff;
               rsp_in.event_count    = events_ff;
               rsp_in.reaction       = reaction_ff;
               rsp_in.target_reached = ((COUNT_BITS + 1)'(wild_ff) +
                                        (COUNT_BITS + 1)'(mutant_ff)) ==
                                       (COUNT_BITS + 1)'(target_ff);
               rsp_in.extinct        = ext_ff;
               rsp_in.saturated      = sat_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wild_ff      <= '0;
         mutant_ff    <= '0;
         events_ff    <= '0;
         death_ff     <= '0;
         mutation_ff  <= '0;
         fitness_ff   <= FITNESS_ONE;
         target_ff    <= '0;
         k_ff         <= '0;
         reaction_ff  <= RX_NONE;
         ext_ff       <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wild_ff      <= wild_in;
         mutant_ff    <= mutant_in;
         events_ff    <= events_in;
         death_ff     <= death_in;
         mutation_ff  <= mutation_in;
         fitness_ff   <= fitness_in;
         target_ff    <= target_in;
         k_ff         <= k_in;
         reaction_ff  <= reaction_in;
         ext_ff       <= ext_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
      pwd_ff  <= pwd_in;
      pmb_ff  <= pmb_in;
      pmd_ff  <= pmd_in;
      pmu_ff  <= pmu_in;
      sum_ff  <= sum_in;
      lhs_ff  <= lhs_in;
      rsp_ff  <= rsp_in;
   end

   assign csr_if.ready          = 1'b1;
   assign req_if.ready          = req_ready;
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.wild_count     = rsp_ff.wild_count;
   assign rsp_if.mutant_count   = rsp_ff.mutant_count;
   assign rsp_if.event_count    = rsp_ff.event_count;
   assign rsp_if.reaction       = rsp_ff.reaction;
   assign rsp_if.target_reached = rsp_ff.target_reached;
   assign rsp_if.extinct        = rsp_ff.extinct;
   assign rsp_if.saturated      = rsp_ff.saturated;

   `BDM_ASSERT(a_mul_done_in_mul_state, clock, reset, mul_done |-> (state_ff == ST_MUL_WD || state_ff == ST_MUL_MB || state_ff == ST_MUL_MD || state_ff == ST_MUL_MU || state_ff == ST_MUL_LHS), "multiplier done outside a multiply state")
   `BDM_ASSERT(a_extinct_no_reaction, clock, reset, rsp_if.valid && rsp_if.extinct |-> rsp_if.reaction == RX_NONE, "extinct transaction reports a reaction")
   `BDM_ASSERT(a_saturate_on_growth, clock, reset, rsp_if.valid && rsp_if.saturated |-> (rsp_if.reaction == RX_WILD_BIRTH || rsp_if.reaction == RX_MUT_BIRTH || rsp_if.reaction == RX_MUTATION), "saturation without a growth reaction")
   `BDM_ASSERT_NEXT(a_load_sets_counts, clock, reset, req_if.valid && req_if.ready && req_if.action == ACT_LOAD, wild_ff == $past(req_if.initial_wild) && mutant_ff == '0 && events_ff == '0, "load transaction did not set counts")

endmodule

@@ bench/bdm_ssa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSA step scoreboard
// Watches the register, request and response channels of the SSA step unit.
// Keeps its own copy of the rates and the cell counts and predicts every
// response with exact wide integer arithmetic. It then compares each accepted
// response, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module bdm_ssa_checker import bdm_ssa_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   bdm_ssa_csr_if csr_if,
   bdm_ssa_req_if req_if,
   bdm_ssa_rsp_if rsp_if,
   output int     fail_count,
   output int     pending
);

   typedef logic [255:0] wide_type;

   logic [RATE_BITS-1:0]   death_rate_q;
   logic [RATE_BITS-1:0]   mutation_rate_q;
   logic [RATE_BITS-1:0]   fitness_q;
   logic [TARGET_BITS-1:0] target_q;
   logic [COUNT_BITS-1:0]  wild_q;
   logic [COUNT_BITS-1:0]  mutant_q;
   logic [COUNT_BITS-1:0]  events_q;
   rsp_data_type           expected_q[$];
   int                     fails = 0;

   function automatic void check_field(string name, logic [COUNT_BITS-1:0] want,
                                       logic [COUNT_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   // advance the shadow counts by one transaction and return the response
   function automatic rsp_data_type next_counts(logic act, logic [COUNT_BITS-1:0] init,
                                                logic [RANDOM_BITS-1:0] frac);
      wide_type     term [TERM_COUNT];
      wide_type     total;
      wide_type     running;
      wide_type     scaled;
      reaction_type pick;
      logic         held;
      logic         gone;
      logic         found;
      rsp_data_type res;
      int           k;
      pick  = RX_NONE;
      held  = 1'b0;
      gone  = 1'b0;
      found = 1'b0;
      if (act == ACT_LOAD) begin
         wild_q   = init;
         mutant_q = '0;
         events_q = '0;
         gone     = (init == '0);
      end else if (wild_q == '0 && mutant_q == '0) begin
         gone = 1'b1;
      end else begin
         term[0] = wide_type'(wild_q) << FRAC_BITS;
         term[1] = wide_type'(wild_q) * wide_type'(death_rate_q);
         term[2] = wide_type'(mutant_q) * wide_type'(fitness_q);
         term[3] = (term[2] * wide_type'(death_rate_q)) >> FRAC_BITS;
         term[4] = wide_type'(wild_q) * wide_type'(mutation_rate_q);
         total = '0;
         for (k = 0; k < TERM_COUNT; k++) begin
            total += term[k];
         end
         if (total != '0) begin
            scaled  = total * wide_type'(frac);
            running = '0;
            pick    = RX_MUTATION;
            for (k = 0; k < TERM_COUNT - 1; k++) begin
               running += term[k];
               if (!found && scaled < (running << RANDOM_BITS)) begin
                  pick  = reaction_type'(k);
                  found = 1'b1;
               end
            end
            case (pick)
               RX_WILD_BIRTH: begin
                  if (wild_q == COUNT_MAX) held = 1'b1;
                  else wild_q = wild_q + COUNT_BITS'(1);
               end
               RX_WILD_DEATH: begin
                  if (wild_q != '0) wild_q = wild_q - COUNT_BITS'(1);
               end
               RX_MUT_BIRTH: begin
                  if (mutant_q == COUNT_MAX) held = 1'b1;
                  else mutant_q = mutant_q + COUNT_BITS'(1);
               end
               RX_MUT_DEATH: begin
                  if (mutant_q != '0) mutant_q = mutant_q - COUNT_BITS'(1);
               end
               default: begin
                  if (mutant_q == COUNT_MAX) held = 1'b1;
                  else mutant_q = mutant_q + COUNT_BITS'(1);
                  if (events_q == COUNT_MAX) held = 1'b1;
                  else events_q = events_q + COUNT_BITS'(1);
               end
            endcase
         end
      end
      res.wild_count     = wild_q;
      res.mutant_count   = mutant_q;
      res.event_count    = events_q;
      res.reaction       = pick;
      res.target_reached = ((COUNT_BITS+1)'(wild_q) + (COUNT_BITS+1)'(mutant_q))
                           == (COUNT_BITS+1)'(target_q);
      res.extinct        = gone;
      res.saturated      = held;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         death_rate_q    = '0;
         mutation_rate_q = '0;
         fitness_q       = FITNESS_ONE;
         target_q        = '0;
         wild_q          = '0;
         mutant_q        = '0;
         events_q        = '0;
         expected_q.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_DEATH_RATE:     death_rate_q    = csr_if.data;
               CSR_MUTATION_RATE:  mutation_rate_q = csr_if.data;
               CSR_MUTANT_FITNESS: fitness_q       = csr_if.data;
               CSR_TARGET_SIZE:    target_q        = csr_if.data[TARGET_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no transaction outstanding");
               fails++;
            end else begin
               want = expected_q.pop_front();
               check_field("wild_count", want.wild_count, rsp_if.wild_count);
               check_field("mutant_count", want.mutant_count, rsp_if.mutant_count);
               check_field("event_count", want.event_count, rsp_if.event_count);
               check_field("reaction", want.reaction, rsp_if.reaction);
               check_field("target_reached", want.target_reached, rsp_if.target_reached);
               check_field("extinct", want.extinct, rsp_if.extinct);
               check_field("saturated", want.saturated, rsp_if.saturated);
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_q.push_back(next_counts(req_if.action, req_if.initial_wild,
                                             req_if.random_fraction));
         end
      end
      pending    <= expected_q.size();
      fail_count <= fails;
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSA step unit testbench
// Drives load and step transactions through the SSA step unit under a series
// of rate and target settings. A short directed run covers extinction,
// saturation, zero propensity and every reaction. Random load-then-step
// sequences follow, mixed with noise. Sender bursts and receiver stalls are
// random. The scoreboard predicts and checks every response.
// ----------------------------------------------------------------------------
module tb;
   import bdm_ssa_pkg::*;

   localparam int     HALF_PERIOD  = 10;
   localparam int     RANDOM_ITEMS = 1600;
   localparam int     LONG_HOLD    = 400;
   localparam longint TIMEOUT_NS   = 25_000_000;
   localparam logic [RATE_BITS-1:0] RATE_MAX = '1;

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_SPARSE,
      STALL_RARE
   } stall_mode_type;

   logic           clock = 1'b0;
   logic           reset;
   int             fail_count;
   int             pending;
   int             burst_left = 0;
   int             hold_left = 0;
   int             mode_left = 0;
   bit             long_hold_req;
   bit             long_hold_taken = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;

   bdm_ssa_csr_if csr_bus();
   bdm_ssa_req_if req_bus();
   bdm_ssa_rsp_if rsp_bus();

   birth_death_mutation_ssa_step_unit i_dut (
      .clock,
      .reset,
      .csr_if(csr_bus),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   bdm_ssa_checker i_checker (
      .clock,
      .reset,
      .csr_if(csr_bus),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .fail_count,
      .pending
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_req && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         hold_left       <= LONG_HOLD;
         rsp_bus.ready   <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:   rsp_bus.ready <= 1'b1;
            STALL_HALF:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_bus.ready <= 1'b1;
               if ($urandom_range(0, 499) == 0) hold_left <= $urandom_range(50, 250);
            end
         endcase
      end
   end

   function automatic logic [COUNT_BITS-1:0] rand_count();
      return COUNT_BITS'({$urandom, $urandom});
   endfunction

   function automatic logic [RATE_BITS-1:0] pick_rate();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return RATE_MAX;
         2: return FITNESS_ONE;
         3: return RATE_BITS'({$urandom, $urandom});
         4: return FITNESS_ONE >> $urandom_range(1, 12);
         default: return (RATE_BITS'($urandom_range(1, 4)) * FITNESS_ONE) >> 1;
      endcase
   endfunction

   // upper data bits above the target width are noise
   function automatic logic [RATE_BITS-1:0] pick_target();
      logic [RATE_BITS-1:0] value;
      value = RATE_BITS'({$urandom, $urandom});
      case ($urandom_range(0, 4))
         0: value[TARGET_BITS-1:0] = '0;
         1: ;
         2: value[TARGET_BITS-1:0] = COUNT_MAX;
         default: value[TARGET_BITS-1:0] = TARGET_BITS'($urandom_range(1, 30));
      endcase
      return value;
   endfunction

   function automatic logic [COUNT_BITS-1:0] pick_wild();
      case ($urandom_range(0, 9))
         0: return rand_count();
         1: return COUNT_MAX - COUNT_BITS'($urandom_range(0, 2));
         2: return '0;
         default: return COUNT_BITS'($urandom_range(1, 20));
      endcase
   endfunction

   function automatic logic [RANDOM_BITS-1:0] pick_frac();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(logic act, logic [COUNT_BITS-1:0] init,
                       logic [RANDOM_BITS-1:0] frac);
      int gap;
      req_bus.valid           <= 1'b1;
      req_bus.action          <= act;
      req_bus.initial_wild    <= init;
      req_bus.random_fraction <= frac;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 90) : $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic configure(logic [RATE_BITS-1:0] death, logic [RATE_BITS-1:0] mutation,
                            logic [RATE_BITS-1:0] fitness, logic [RATE_BITS-1:0] target);
      logic [RATE_BITS-1:0]   value [4];
      logic [CSR_INDEX_W-1:0] index [4];
      int                     i;
      value = '{death, mutation, fitness, target};
      index = '{CSR_DEATH_RATE, CSR_MUTATION_RATE, CSR_MUTANT_FITNESS, CSR_TARGET_SIZE};
      drain();
      for (i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= index[i];
         csr_bus.data  <= value[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int random_sent;
      int phase_end;
      int steps;
      reset                   = 1'b1;
      csr_bus.valid           = 1'b0;
      csr_bus.index           = CSR_DEATH_RATE;
      csr_bus.data            = '0;
      req_bus.valid           = 1'b0;
      req_bus.action          = ACT_LOAD;
      req_bus.initial_wild    = '0;
      req_bus.random_fraction = '0;
      long_hold_req           = 1'b0;
      random_sent             = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset rates: births only
      send(ACT_STEP, '0, '0);
      send(ACT_LOAD, '0, '1);
      send(ACT_LOAD, COUNT_MAX, '0);
      send(ACT_STEP, '0, '0);
      send(ACT_STEP, '1, '1);
      send(ACT_LOAD, COUNT_BITS'(1), '0);
      send(ACT_STEP, '0, '1);

      // mutation, then wild death, then zero total propensity
      configure(FITNESS_ONE, RATE_MAX, '0, RATE_BITS'(1));
      send(ACT_LOAD, COUNT_BITS'(1), '0);
      send(ACT_STEP, '0, '1);
      send(ACT_STEP, '0, RANDOM_BITS'(3) << 23);
      send(ACT_STEP, rand_count(), $urandom);

      // mutant birth and death, extinction, wild death and saturation
      configure(RATE_MAX, '0, RATE_MAX, {{(RATE_BITS-TARGET_BITS){1'b1}}, COUNT_MAX});
      send(ACT_STEP, '0, '0);
      send(ACT_STEP, '0, '1);
      send(ACT_STEP, '0, '1);
      send(ACT_STEP, '0, '0);
      send(ACT_LOAD, COUNT_MAX, '0);
      send(ACT_STEP, '0, '1);
      send(ACT_STEP, '0, '0);
      send(ACT_STEP, '0, '0);

      long_hold_req <= 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         configure(pick_rate(), pick_rate(), pick_rate(), pick_target());
         phase_end = random_sent + $urandom_range(60, 140);
         while (random_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               send(1'($urandom), rand_count(), $urandom);
               random_sent++;
            end else begin
               send(ACT_LOAD, pick_wild(), $urandom);
               random_sent++;
               steps = $urandom_range(1, 25);
               repeat (steps) begin
                  send(ACT_STEP, rand_count(), pick_frac());
                  random_sent++;
               end
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS birth_death_mutation_ssa_step_unit");
      end else begin
         $display("FAIL birth_death_mutation_ssa_step_unit");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL birth_death_mutation_ssa_step_unit");
      $finish;
   end

endmodule

@@ birth_death_mutation_ssa_step_unit.f @@
+incdir+design
design/bdm_ssa_pkg.sv
design/bdm_ssa_csr_if.sv
design/bdm_ssa_req_if.sv
design/bdm_ssa_rsp_if.sv
design/bdm_ssa_mul.sv
design/birth_death_mutation_ssa_step_unit.sv
bench/bdm_ssa_checker.sv
bench/tb.sv
